FILE: rtl/rmst_pkg.sv
// Shared types and constants of the range-minimum segment tree unit.
package rmst_pkg;

    localparam int LEAF_COUNT_DEF = 1024;
    localparam int IDX_W          = 10;
    localparam int VAL_W          = 32;

    localparam logic signed [VAL_W-1:0] MIN_IDENTITY = 32'sh7FFF_FFFF;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_U_WRITE,
        ST_U_MERGE,
        ST_Q_STEP,
        ST_Q_ACC
    } t_state;

endpackage

FILE: rtl/range_min_segment_tree_unit.sv
// Top level of the range-minimum segment tree: node memory, sequencer and shared compare unit.
//
//  Channel   Handshake                     Payload
//  --------  ----------------------------  ------------------------------------------------
//  request   start high while busy low     i_opcode, i_element_index, i_new_value,
//                                          i_range_low, i_range_high
//  result    o_result_valid for one cycle  o_range_minimum
//
// An update walks from its leaf to the root: each level costs one read of the sibling
// node and one write of the parent, both through the single node memory. An update whose
// index lies past the last leaf is dropped in its accept cycle. A non-empty query is a
// bottom-up walk that reads at most two nodes per level through the one read port. After
// reset a clearing pass writes the largest signed value into all 2*LEAF_COUNT-1 nodes,
// one node per cycle; busy stays high until it ends. The receiver cannot stall results,
// so the strobe is raised exactly once per query.
module range_min_segment_tree_unit
    import rmst_pkg::*;
#(
    parameter int LEAF_COUNT = LEAF_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_opcode,
    input  logic [IDX_W-1:0]        i_element_index,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [IDX_W-1:0]        i_range_low,
    input  logic [IDX_W-1:0]        i_range_high,
    output logic                    o_result_valid,
    output logic signed [VAL_W-1:0] o_range_minimum
);

    // Nodes are stored in heap order. Internally node numbers are 1-based, so the
    // root is node 1, the children of node p are 2p and 2p+1, and leaf k is node
    // LEAF_COUNT+k; the memory address is the node number minus one.
    localparam int NODE_COUNT = 2 * LEAF_COUNT - 1;
    localparam int AW         = $clog2(NODE_COUNT);
    localparam int NW         = AW + 1;
    localparam int CW         = (NW > IDX_W) ? NW : IDX_W;

    t_state                  r_state, n_state;
    logic [AW-1:0]           r_clr, n_clr;
    logic [NW-1:0]           r_node, n_node;
    logic [NW-1:0]           r_l, n_l;
    logic [NW-1:0]           r_r, n_r;
    logic signed [VAL_W-1:0] r_cur, n_cur;
    logic signed [VAL_W-1:0] r_acc, n_acc;
    logic                    r_res_valid, n_res_valid;
    logic signed [VAL_W-1:0] r_res, n_res;

    logic signed [VAL_W-1:0] r_tree [0:NODE_COUNT-1];
    logic signed [VAL_W-1:0] r_rd_data;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;

    logic signed [VAL_W-1:0] cmp_a;
    logic signed [VAL_W-1:0] cmp_min;

    logic [CW-1:0] idx_w;
    logic [CW-1:0] qa_w;
    logic [CW-1:0] qb_clamped;
    logic          accept;

    // Node memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_tree[mem_raddr];
    end

    // The one compare unit: it folds the node just read into the running minimum of
    // the walk in progress, the new child value for an update, the partial answer
    // for a query.
    assign cmp_a   = (r_state == ST_Q_ACC) ? r_acc : r_cur;
    assign cmp_min = (r_rd_data < cmp_a) ? r_rd_data : cmp_a;

    assign accept = start && !busy;
    assign idx_w  = CW'(i_element_index);
    assign qa_w   = CW'(i_range_low);

    // A range that runs past the last leaf only covers the leaves that exist.
    assign qb_clamped = (CW'(i_range_high) >= CW'(LEAF_COUNT)) ? CW'(LEAF_COUNT - 1)
                                                               : CW'(i_range_high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node <= n_node;
        r_l    <= n_l;
        r_r    <= n_r;
        r_cur  <= n_cur;
        r_acc  <= n_acc;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_node      = r_node;
        n_l         = r_l;
        n_r         = r_r;
        n_cur       = r_cur;
        n_acc       = r_acc;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = AW'(r_node - NW'(1));
        mem_wdata   = r_cur;
        mem_raddr   = '0;

        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = MIN_IDENTITY;
                n_clr     = r_clr + AW'(1);
                if (r_clr == AW'(NODE_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (accept) begin
                    if (i_opcode == OP_UPDATE) begin
                        // An index past the last leaf leaves the tree untouched.
                        if (idx_w < CW'(LEAF_COUNT)) begin
                            n_node  = NW'(idx_w + CW'(LEAF_COUNT));
                            n_cur   = i_new_value;
                            n_state = ST_U_WRITE;
                        end
                    end else begin
                        if (qa_w >= CW'(LEAF_COUNT) || qa_w > qb_clamped) begin
                            n_res_valid = 1'b1;
                            n_res       = MIN_IDENTITY;
                        end else begin
                            n_l     = NW'(qa_w + CW'(LEAF_COUNT));
                            n_r     = NW'(qb_clamped + CW'(LEAF_COUNT) + CW'(1));
                            n_acc   = MIN_IDENTITY;
                            n_state = ST_Q_STEP;
                        end
                    end
                end
            end

            ST_U_WRITE: begin
                mem_we    = 1'b1;
                mem_raddr = AW'((r_node ^ NW'(1)) - NW'(1));
                if (r_node == NW'(1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_U_MERGE;
                end
            end

            ST_U_MERGE: begin
                n_cur   = cmp_min;
                n_node  = r_node >> 1;
                n_state = ST_U_WRITE;
            end

            ST_Q_STEP: begin
                if (r_l >= r_r) begin
                    n_res_valid = 1'b1;
                    n_res       = r_acc;
                    n_state     = ST_IDLE;
                end else if (r_l[0]) begin
                    mem_raddr = AW'(r_l - NW'(1));
                    n_l       = r_l + NW'(1);
                    n_state   = ST_Q_ACC;
                end else if (r_r[0]) begin
                    mem_raddr = AW'(r_r - NW'(2));
                    n_r       = r_r - NW'(1);
                    n_state   = ST_Q_ACC;
                end else begin
                    n_l = r_l >> 1;
                    n_r = r_r >> 1;
                end
            end

            ST_Q_ACC: begin
                n_acc   = cmp_min;
                n_state = ST_Q_STEP;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_valid  = r_res_valid;
    assign o_range_minimum = r_res;

    // A result only follows a query that ended its walk or was empty at once.
    a_result_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == ST_Q_STEP ||
                                 (r_state == ST_IDLE && start && i_opcode == OP_QUERY)))
        else $error("result strobe without a finished query");

    // Queries never write the node memory.
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ST_CLEAR || r_state == ST_U_WRITE))
        else $error("node memory written outside clearing or update");

    // The update walk stays on real nodes.
    a_update_node_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_U_WRITE) |-> (r_node != '0 && r_node <= NW'(NODE_COUNT)))
        else $error("update walk left the tree");

endmodule

FILE: dv/range_min_segment_tree_unit_tb.sv
// Self-checking testbench for the range-minimum segment tree unit: directed and random requests.
`timescale 1ns / 100ps

module range_min_segment_tree_unit_tb;
    import rmst_pkg::*;

    // The block is built with its default leaf count, so every 10-bit index names a real leaf.
    localparam int LEAVES = LEAF_COUNT_DEF;

    // After the last result we let a little more than the slowest walk pass before ending.
    localparam int SETTLE_CYCLES = 80;

    localparam logic signed [VAL_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;

    logic                    i_clk           = 1'b0;
    logic                    i_rst_n         = 1'b0;
    logic                    start           = 1'b0;
    logic                    busy;
    logic                    i_opcode        = OP_UPDATE;
    logic [IDX_W-1:0]        i_element_index = '0;
    logic signed [VAL_W-1:0] i_new_value     = '0;
    logic [IDX_W-1:0]        i_range_low     = '0;
    logic [IDX_W-1:0]        i_range_high    = '0;
    logic                    o_result_valid;
    logic signed [VAL_W-1:0] o_range_minimum;

    // Our own copy of the leaves. Every interior node of the tree is the minimum of the
    // leaves under it, so the minimum over a leaf range is all that a query has to match.
    logic signed [VAL_W-1:0] leaf_values [LEAVES];

    // Minimums predicted for accepted queries, oldest first.
    logic signed [VAL_W-1:0] pending_minimums [$];
    logic signed [VAL_W-1:0] oldest_minimum;

    int unsigned error_count = 0;

    range_min_segment_tree_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_element_index (i_element_index),
        .i_new_value     (i_new_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .o_result_valid  (o_result_valid),
        .o_range_minimum (o_range_minimum)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Minimum over the inclusive leaf range. A reversed range is empty and yields the
    // identity of the minimum, the largest signed value.
    function automatic logic signed [VAL_W-1:0] range_min_of(input int lo, input int hi);
        logic signed [VAL_W-1:0] acc;
        acc = MIN_IDENTITY;
        for (int k = lo; k <= hi; k++) begin
            if (leaf_values[k] < acc) begin
                acc = leaf_values[k];
            end
        end
        return acc;
    endfunction

    // Values lean on the two extremes and on small numbers around zero, so that ties and
    // sign changes show up often among the leaves of one range.
    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: begin
                return MOST_NEGATIVE;
            end
            1: begin
                return MIN_IDENTITY;
            end
            2, 3: begin
                return $signed($urandom_range(0, 64)) - 32;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    // Sends one request. It is entered just after a rising edge and returns just after the
    // edge that accepted the request, with start still high: the caller either sends the
    // next request in the same time step or lowers start through wait_until_drained.
    // Handshake signals are sampled at the falling edge, where nothing is changing, and
    // the prediction is made there, before the edge that accepts the request.
    task automatic send_request(input logic op, input int idx,
                                input logic signed [VAL_W-1:0] val,
                                input int lo, input int hi);
        int unsigned gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            // Idle cycles carry random noise on the payload, which the block must ignore.
            start           <= 1'b0;
            i_opcode        <= 1'($urandom);
            i_element_index <= IDX_W'($urandom);
            i_new_value     <= $urandom;
            i_range_low     <= IDX_W'($urandom);
            i_range_high    <= IDX_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_opcode        <= op;
        i_element_index <= IDX_W'(idx);
        i_new_value     <= val;
        i_range_low     <= IDX_W'(lo);
        i_range_high    <= IDX_W'(hi);
        @(negedge i_clk);
        while (busy) begin
            @(negedge i_clk);
        end
        if (op == OP_UPDATE) begin
            leaf_values[idx] = val;
        end else begin
            pending_minimums.push_back(range_min_of(lo, hi));
        end
        @(posedge i_clk);
    endtask

    // Lowers start, waits for every predicted minimum to arrive, then lets the slowest walk
    // finish so that a trailing update has surely reached the root.
    task automatic wait_until_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_minimums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // A tree that was only cleared must answer the largest signed value everywhere,
    // including for a reversed range.
    task automatic test_cleared_tree();
        send_request(OP_QUERY, $urandom, $urandom, 0, LEAVES - 1);
        send_request(OP_QUERY, $urandom, $urandom, 0, 0);
        send_request(OP_QUERY, $urandom, $urandom, LEAVES - 1, LEAVES - 1);
        send_request(OP_QUERY, $urandom, $urandom, LEAVES - 1, 0);
        send_request(OP_QUERY, $urandom, $urandom, 5, 4);
        wait_until_drained();
    endtask

    // Extreme values at the edge leaves and small ones in the middle, a leaf raised back to the
    // identity so that its ancestors must grow again, and ranges just missing a written leaf.
    task automatic test_extremes();
        send_request(OP_UPDATE, 0, MOST_NEGATIVE, $urandom, $urandom);
        send_request(OP_QUERY, $urandom, $urandom, 0, LEAVES - 1);
        send_request(OP_QUERY, $urandom, $urandom, 1, LEAVES - 1);
        send_request(OP_UPDATE, LEAVES - 1, -1, $urandom, $urandom);
        send_request(OP_QUERY, $urandom, $urandom, 1, LEAVES - 1);
        send_request(OP_QUERY, $urandom, $urandom, 1, LEAVES - 2);
        send_request(OP_UPDATE, 0, MIN_IDENTITY, $urandom, $urandom);
        send_request(OP_QUERY, $urandom, $urandom, 0, 0);
        send_request(OP_QUERY, $urandom, $urandom, 0, LEAVES - 1);
        send_request(OP_UPDATE, LEAVES / 2, 0, $urandom, $urandom);
        send_request(OP_UPDATE, LEAVES / 2 - 1, 1, $urandom, $urandom);
        send_request(OP_QUERY, $urandom, $urandom, LEAVES / 2 - 1, LEAVES / 2);
        send_request(OP_QUERY, $urandom, $urandom, 0, LEAVES / 2 - 1);
        send_request(OP_QUERY, $urandom, $urandom, LEAVES / 2 + 1, LEAVES - 2);
        send_request(OP_UPDATE, LEAVES - 1, MIN_IDENTITY, $urandom, $urandom);
        send_request(OP_QUERY, $urandom, $urandom, 0, LEAVES - 1);
        send_request(OP_QUERY, $urandom, $urandom, LEAVES - 1, LEAVES - 2);
        wait_until_drained();
    endtask

    // Random updates and queries. Most updates land in a window of the given width so that
    // the queries, many of which also start in it, keep meeting freshly written leaves.
    task automatic test_random_mix(input int count, input int window);
        int base;
        int lo;
        int hi;
        base = $urandom_range(0, LEAVES - window);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                if ($urandom_range(0, 9) < 7) begin
                    lo = base + $urandom_range(0, window - 1);
                end else begin
                    lo = $urandom_range(0, LEAVES - 1);
                end
                send_request(OP_UPDATE, lo, random_value(), $urandom, $urandom);
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        lo = $urandom_range(1, LEAVES - 1);
                        hi = $urandom_range(0, lo - 1);
                    end
                    1: begin
                        lo = 0;
                        hi = LEAVES - 1;
                    end
                    2, 3, 4, 5: begin
                        lo = base + $urandom_range(0, window - 1);
                        hi = lo + $urandom_range(0, 15);
                        if (hi > LEAVES - 1) begin
                            hi = LEAVES - 1;
                        end
                    end
                    default: begin
                        lo = $urandom_range(0, LEAVES - 1);
                        hi = $urandom_range(lo, LEAVES - 1);
                    end
                endcase
                send_request(OP_QUERY, $urandom, $urandom, lo, hi);
            end
        end
        wait_until_drained();
    endtask

    // Results are compared at the falling edge, in the middle of the one cycle that the
    // strobe is high.
    always @(negedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (pending_minimums.size() == 0) begin
                $error("range_minimum: unexpected result, actual %0d", o_range_minimum);
                error_count++;
            end else begin
                oldest_minimum = pending_minimums.pop_front();
                if (o_range_minimum !== oldest_minimum) begin
                    $error("range_minimum: expected %0d actual %0d",
                           oldest_minimum, o_range_minimum);
                    error_count++;
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < LEAVES; k++) begin
            leaf_values[k] = MIN_IDENTITY;
        end
        // The clearing pass that follows reset keeps busy high, and the first request simply
        // waits for it.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_cleared_tree();
        test_extremes();
        test_random_mix(400, 16);
        test_random_mix(450, 128);
        test_random_mix(400, LEAVES);

        if (error_count == 0) begin
            $display("PASS range_min_segment_tree_unit");
        end else begin
            $display("FAIL range_min_segment_tree_unit");
        end
        $finish;
    end

    // The slowest correct run needs well under a tenth of this time.
    initial begin
        #(20_000_000);
        $display("FAIL range_min_segment_tree_unit");
        $finish;
    end

endmodule
